// ===== hdl/fbc_pkg.sv =====
// Shared types and constants for the frustum box cull block.
// Used by every module under hdl; depends on nothing else.
package fbc_pkg;

  // Q16.16 fraction bits and the number of clip planes.
  localparam int Q_FRAC     = 16;
  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;
  localparam int NUM_ELEMS  = 16;

  // Widths: element, plane coefficient (sum of two elements), product, dot sum.
  localparam int ELEM_W  = 32;
  localparam int COEF_W  = ELEM_W + 1;
  localparam int PROD_W  = COEF_W + ELEM_W;
  localparam int SUM_W   = PROD_W + 2;

  // Operation codes carried in the op field.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  // Full matrix store, column-major, element index = column*4 + row.
  typedef logic [NUM_ELEMS-1:0][ELEM_W-1:0] mat_t;

  // One clip plane: x, y, z, w coefficients and its degenerate flag.
  typedef struct packed {
    logic                  degen;
    logic [3:0][COEF_W-1:0] c;
  } plane_t;

  // Box with its corners put in order per axis.
  typedef struct packed {
    logic [NUM_AXES-1:0][ELEM_W-1:0] lo;
    logic [NUM_AXES-1:0][ELEM_W-1:0] hi;
  } box_t;

  // Load enables of the pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage

// ===== hdl/fbc_plane_setup.sv =====
// First pipeline stage: derives the six clip planes from the matrix store and
// puts the box corners in order. Depends on fbc_pkg.
module fbc_plane_setup import fbc_pkg::*; (
  input  logic                           clk,
  input  pipe_en_t                       en,
  input  mat_t                           mat,
  input  logic [NUM_AXES-1:0][ELEM_W-1:0] box_min,
  input  logic [NUM_AXES-1:0][ELEM_W-1:0] box_max,
  output plane_t [NUM_PLANES-1:0]        plane_r,
  output box_t                           box_r
);

  plane_t [NUM_PLANES-1:0] plane_nxt;
  box_t                    box_nxt;

  // Plane p uses axis p/2; even planes add the axis row, odd planes subtract it.
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    localparam int AXIS = p / 2;
    logic [3:0][COEF_W-1:0] coef;
    for (genvar j = 0; j < 4; j++) begin : g_comp
      logic signed [COEF_W-1:0] w_row;
      logic signed [COEF_W-1:0] a_row;
      assign w_row = COEF_W'($signed(mat[j*4 + 3]));
      assign a_row = COEF_W'($signed(mat[j*4 + AXIS]));
      if ((p % 2) == 0) begin : g_add
        assign coef[j] = w_row + a_row;
      end else begin : g_sub
        assign coef[j] = w_row - a_row;
      end
    end
    assign plane_nxt[p].c     = coef;
    assign plane_nxt[p].degen = (coef[0] == '0) && (coef[1] == '0) && (coef[2] == '0);
  end

  // Order each axis so that lo holds the smaller bound.
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      if ($signed(box_min[k]) <= $signed(box_max[k])) begin
        box_nxt.lo[k] = box_min[k];
        box_nxt.hi[k] = box_max[k];
      end else begin
        box_nxt.lo[k] = box_max[k];
        box_nxt.hi[k] = box_min[k];
      end
    end
  end

  // Stage registers, payload only.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      plane_r <= plane_nxt;
      box_r   <= box_nxt;
    end
  end

endmodule

// ===== hdl/fbc_plane_eval.sv =====
// Second and third pipeline stages for one clip plane: multiplies the
// coefficients by the farthest box corner and tests the sign. Depends on fbc_pkg.
module fbc_plane_eval import fbc_pkg::*; (
  input  logic     clk,
  input  pipe_en_t en,
  input  plane_t   plane,
  input  box_t     box,
  output logic     reject_r
);

  logic signed [NUM_AXES-1:0][PROD_W-1:0] prod_r;
  logic signed [NUM_AXES-1:0][PROD_W-1:0] prod_nxt;
  logic signed [COEF_W-1:0]               w_r;
  logic                                   degen_r;
  logic signed [SUM_W-1:0]                sum;
  logic                                   reject_nxt;

  // The corner with the largest dot product takes the upper bound where the
  // coefficient is non-negative and the lower bound elsewhere.
  always_comb begin
    logic signed [COEF_W-1:0] c_s;
    logic signed [ELEM_W-1:0] x_s;
    for (int j = 0; j < NUM_AXES; j++) begin
      c_s = $signed(plane.c[j]);
      x_s = c_s[COEF_W-1] ? $signed(box.lo[j]) : $signed(box.hi[j]);
      prod_nxt[j] = PROD_W'(c_s) * PROD_W'(x_s);
    end
  end

  // Stage 2: products registered.
  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_r  <= prod_nxt;
      w_r     <= $signed(plane.c[3]);
      degen_r <= plane.degen;
    end
  end

  // The box is outside when even its farthest corner lies below the plane.
  always_comb begin
    sum = SUM_W'($signed(prod_r[0])) + SUM_W'($signed(prod_r[1]))
        + SUM_W'($signed(prod_r[2])) + (SUM_W'(w_r) <<< Q_FRAC);
    reject_nxt = !degen_r && sum[SUM_W-1];
  end

  // Stage 3: per-plane verdict registered.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      reject_r <= reject_nxt;
    end
  end

endmodule

// ===== hdl/frustum_box_cull.sv =====
// Frustum box cull: for each test beat, reports whether an axis-aligned box
// may be inside the view frustum of a 4x4 view-projection matrix.
//
// Input channel (in_valid / in_ready): in_op selects a matrix element write
// (in_elem_index, in_elem_value, Q16.16) or a box test (in_min_*, in_max_*).
// A write beat updates the matrix store at once and gives no result; a test
// beat issued in the next cycle already sees the new element.
// Result channel (out_valid / out_ready): one beat carrying out_visible per
// test beat, in order.
// A test beat is registered by plane setup at the edge that accepts it, then
// moves through the corner multiply, dot-product sum and sign, and output
// register stages before out_valid rises.
// Throughput: one beat per cycle while out_ready stays high; the 18 parallel
// 33x32 multipliers let a new box enter every cycle when nothing stalls.
// Reset (rst_n low, synchronous) empties the pipeline and clears the matrix
// store to zero, so that every box reads as visible until planes are loaded.
// When the receiver stalls, each stage holds its beat and bubbles close up;
// in_ready drops only when all four stages hold a beat.
module frustum_box_cull import fbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [3:0]  in_elem_index,
  input  logic signed [31:0] in_elem_value,
  input  logic signed [31:0] in_min_x,
  input  logic signed [31:0] in_min_y,
  input  logic signed [31:0] in_min_z,
  input  logic signed [31:0] in_max_x,
  input  logic signed [31:0] in_max_y,
  input  logic signed [31:0] in_max_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_visible
);

  mat_t                    mat_r;
  logic                    v1_r, v2_r, v3_r;
  logic                    out_valid_r;
  logic                    visible_r;
  logic                    rdy1, rdy2, rdy3, rdy4;
  logic                    in_fire;
  pipe_en_t                en;
  plane_t [NUM_PLANES-1:0] plane_s1;
  box_t                    box_s1;
  logic [NUM_PLANES-1:0]   reject_s3;

  // Each stage takes a new beat when it is empty or its successor moves.
  assign rdy4     = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign in_fire  = in_valid && rdy1;
  assign en       = '{s1: rdy1, s2: rdy2, s3: rdy3};

  // Matrix store, written directly by write beats.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= '0;
    end else if (in_fire && (in_op == OP_WRITE)) begin
      mat_r[in_elem_index] <= in_elem_value;
    end
  end

  // Valid bits follow the test beats through the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_fire && (in_op == OP_TEST);
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) out_valid_r <= v3_r;
    end
  end

  fbc_plane_setup u_setup (
    .clk     (clk),
    .en      (en),
    .mat     (mat_r),
    .box_min ({in_min_z, in_min_y, in_min_x}),
    .box_max ({in_max_z, in_max_y, in_max_x}),
    .plane_r (plane_s1),
    .box_r   (box_s1)
  );

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_eval
    fbc_plane_eval u_eval (
      .clk      (clk),
      .en       (en),
      .plane    (plane_s1[p]),
      .box      (box_s1),
      .reject_r (reject_s3[p])
    );
  end

  // Output register: visible unless some plane rejects the box.
  always_ff @(posedge clk) begin
    if (rdy4) begin
      visible_r <= !(|reject_s3);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = visible_r;

`ifndef SYNTHESIS
  // Write beats never enter the pipeline.
  a_write_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_op == OP_WRITE) |=> !v1_r)
    else $error("write beat entered the pipeline");

  // An accepted write lands in the addressed element.
  a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_op == OP_WRITE) |=> mat_r[$past(in_elem_index)] == $past(in_elem_value))
    else $error("matrix write lost");

  // The input stalls only when every stage holds a beat.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !rdy1 |-> v1_r && v2_r && v3_r && out_valid_r)
    else $error("input stalled with a bubble in the pipeline");

  // A beat leaving the last stage reaches the output register.
  a_s3_moves: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && rdy4 |=> out_valid_r)
    else $error("beat dropped between stage 3 and output");
`endif

endmodule

// ===== sim/frustum_box_cull_tb.sv =====
// Self-checking testbench for frustum_box_cull: directed table, then random matrix loads and box
// tests, each result checked against a typed-in answer or an in-bench plane/corner predictor.
// Depends on hdl/fbc_pkg.sv and hdl/frustum_box_cull.sv.
`timescale 1ns / 100ps

module frustum_box_cull_tb;
  import fbc_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RAND_ITEMS  = 480;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 200;
  localparam int END_SETTLE  = 8;

  // Q16.16 values used by the directed table.
  localparam logic [31:0] Q_ONE   = 32'h0001_0000;
  localparam logic [31:0] Q_HALF  = 32'h0000_8000;
  localparam logic [31:0] Q_NHALF = 32'hFFFF_8000;
  localparam logic [31:0] Q_TWO   = 32'h0002_0000;
  localparam logic [31:0] Q_THREE = 32'h0003_0000;
  localparam logic [31:0] Q_NTWO  = 32'hFFFE_0000;
  localparam logic [31:0] Q_NTHR  = 32'hFFFD_0000;
  localparam logic [31:0] Q_MIN   = 32'h8000_0000;
  localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;

  // One input beat as the sender sees it.
  typedef struct packed {
    logic        op;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [31:0] min_z;
    logic [31:0] max_x;
    logic [31:0] max_y;
    logic [31:0] max_z;
  } cull_beat_t;

  // Directed row: a beat, plus a typed-in answer where one is obvious.
  typedef struct packed {
    cull_beat_t beat;
    logic       known;
    logic       want;
  } dir_row_t;

  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [3:0]  in_elem_index;
  logic signed [31:0] in_elem_value;
  logic signed [31:0] in_min_x;
  logic signed [31:0] in_min_y;
  logic signed [31:0] in_min_z;
  logic signed [31:0] in_max_x;
  logic signed [31:0] in_max_y;
  logic signed [31:0] in_max_z;
  logic        out_valid;
  logic        out_ready;
  logic        out_visible;

  // Predictor state and scoreboard.
  logic signed [31:0] mat_model [NUM_ELEMS];
  bit  pending_visible [$];
  int  n_fail;
  int  n_writes;
  int  n_tests;
  int  n_results;
  int  n_culled;
  int  cycle_count;
  int  burst_left;
  logic hold_armed;

  frustum_box_cull dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_elem_index (in_elem_index),
    .in_elem_value (in_elem_value),
    .in_min_x      (in_min_x),
    .in_min_y      (in_min_y),
    .in_min_z      (in_min_z),
    .in_max_x      (in_max_x),
    .in_max_y      (in_max_y),
    .in_max_z      (in_max_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_visible   (out_visible)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Run limit.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Visibility of a box against the six planes of the current matrix, computed exactly.
  function automatic bit box_visible(input cull_beat_t b);
    logic signed [127:0] coef [4];
    logic signed [127:0] lo [3];
    logic signed [127:0] hi [3];
    logic signed [127:0] acc;
    logic signed [127:0] w_one;
    bit all_below;
    w_one = 128'sd1 <<< Q_FRAC;
    lo[0] = $signed(b.min_x);
    lo[1] = $signed(b.min_y);
    lo[2] = $signed(b.min_z);
    hi[0] = $signed(b.max_x);
    hi[1] = $signed(b.max_y);
    hi[2] = $signed(b.max_z);
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int s = 0; s < 2; s++) begin
        // Plane coefficient j is the row-3 element plus or minus the row-a element.
        for (int j = 0; j < 4; j++) begin
          coef[j] = mat_model[j*4 + 3];
          if (s == 0) coef[j] += mat_model[j*4 + a];
          else        coef[j] -= mat_model[j*4 + a];
        end
        // A plane with no x, y or z part never rejects.
        if (coef[0] == 0 && coef[1] == 0 && coef[2] == 0) continue;
        all_below = 1'b1;
        for (int ci = 0; ci < 8; ci++) begin
          acc = coef[0] * (ci[0] ? hi[0] : lo[0])
              + coef[1] * (ci[1] ? hi[1] : lo[1])
              + coef[2] * (ci[2] ? hi[2] : lo[2])
              + coef[3] * w_one;
          if (acc >= 0) all_below = 1'b0;
        end
        if (all_below) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Beat builders; the fields an op ignores carry random junk.
  function automatic dir_row_t w_row(input logic [3:0] idx, input logic [31:0] val);
    dir_row_t r;
    r.beat = '{OP_WRITE, idx, val, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    r.known = 1'b0;
    r.want  = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t t_row(input logic [31:0] mnx, input logic [31:0] mny,
                                     input logic [31:0] mnz, input logic [31:0] mxx,
                                     input logic [31:0] mxy, input logic [31:0] mxz,
                                     input logic known, input logic want);
    dir_row_t r;
    r.beat = '{OP_TEST, 4'($urandom), $urandom, mnx, mny, mnz, mxx, mxy, mxz};
    r.known = known;
    r.want  = want;
    return r;
  endfunction

  // Uniform Q16.16 value in [-range, range].
  function automatic logic [31:0] small_q(input int range);
    return $urandom_range(0, 2 * range) - range;
  endfunction

  // Offer one beat, hold it until accepted, then update the predictor.
  task automatic issue(input cull_beat_t b, input logic known, input logic want);
    bit took;
    in_valid      <= 1'b1;
    in_op         <= b.op;
    in_elem_index <= b.idx;
    in_elem_value <= b.val;
    in_min_x      <= b.min_x;
    in_min_y      <= b.min_y;
    in_min_z      <= b.min_z;
    in_max_x      <= b.max_x;
    in_max_y      <= b.max_y;
    in_max_z      <= b.max_z;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    if (b.op == OP_WRITE) begin
      mat_model[b.idx] = b.val;
      n_writes++;
    end else begin
      pending_visible.push_back(known ? want : box_visible(b));
      n_tests++;
    end
  endtask

  task automatic idle(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Bursts of back-to-back beats separated by short gaps.
  task automatic pace();
    if (burst_left == 0) begin
      idle($urandom_range(1, 6));
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Stop sending until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_visible.size() != 0);
  endtask

  // Result checker: sampled mid-cycle, the beat is taken at the next rising edge.
  always @(negedge clk) begin : check_results
    bit exp_v;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_visible.size() == 0) begin
        $error("visible: no result expected, got %0d", out_visible);
        n_fail++;
      end else begin
        exp_v = pending_visible.pop_front();
        if (exp_v !== out_visible) begin
          $error("visible: expected %0d, got %0d", exp_v, out_visible);
          n_fail++;
        end
      end
      if (out_visible === 1'b0) n_culled++;
    end
  end

  // Receiver: stall pattern changes in phases; one long hold-off once armed.
  initial begin : receiver
    rx_mode_t mode;
    int phase_left;
    int hold_left;
    bit hold_done;
    out_ready  <= 1'b0;
    mode       = RX_STEADY;
    phase_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode       = rx_mode_t'($urandom_range(0, 2));
          phase_left = $urandom_range(16, 80);
        end
        phase_left--;
        case (mode)
          RX_STEADY: out_ready <= 1'b1;
          RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Main stimulus.
  initial begin : stimulus
    dir_row_t dir_table [$];
    dir_row_t row;
    cull_beat_t b;
    logic [31:0] ctr, half;
    int made;
    int pick;
    bit paused;

    n_fail     = 0;
    n_writes   = 0;
    n_tests    = 0;
    n_results  = 0;
    n_culled   = 0;
    burst_left = 0;
    paused     = 1'b0;
    for (int i = 0; i < NUM_ELEMS; i++) mat_model[i] = '0;

    rst_n         <= 1'b0;
    hold_armed    <= 1'b0;
    in_valid      <= 1'b0;
    in_op         <= OP_WRITE;
    in_elem_index <= '0;
    in_elem_value <= '0;
    in_min_x      <= '0;
    in_min_y      <= '0;
    in_min_z      <= '0;
    in_max_x      <= '0;
    in_max_y      <= '0;
    in_max_z      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: reset matrix, degenerate planes, identity planes, extremes.
    dir_table = '{
      t_row('0, '0, '0, '0, '0, '0, 1'b1, 1'b1),
      t_row(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1, 1'b1),
      t_row(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1'b1, 1'b1),
      w_row(4'd15, Q_MIN),
      t_row(Q_TWO, '0, '0, Q_THREE, '0, '0, 1'b1, 1'b1),
      w_row(4'd0, Q_ONE),
      w_row(4'd5, Q_ONE),
      w_row(4'd10, Q_ONE),
      w_row(4'd15, Q_ONE),
      t_row(Q_NHALF, Q_NHALF, Q_NHALF, Q_HALF, Q_HALF, Q_HALF, 1'b0, 1'b0),
      t_row(Q_TWO, '0, '0, Q_THREE, '0, '0, 1'b1, 1'b0),
      t_row(Q_NTHR, '0, '0, Q_NTWO, '0, '0, 1'b0, 1'b0),
      t_row(Q_THREE, '0, '0, Q_TWO, '0, '0, 1'b0, 1'b0),
      t_row(Q_ONE, '0, '0, Q_TWO, '0, '0, 1'b0, 1'b0),
      t_row(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0),
      w_row(4'd3, Q_MAX),
      w_row(4'd12, Q_MIN),
      t_row(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0, 1'b0),
      t_row(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0, 1'b0),
      w_row(4'd7, 32'hFFFF_FFFF),
      w_row(4'd9, 32'h0000_0001),
      t_row('0, '0, '0, Q_ONE, Q_ONE, Q_ONE, 1'b0, 1'b0),
      t_row(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b0, 1'b0)
    };
    foreach (dir_table[i]) begin
      issue(dir_table[i].beat, dir_table[i].known, dir_table[i].want);
      pace();
    end
    drain();

    // Random part; the receiver's long hold-off starts with it.
    hold_armed <= 1'b1;
    made = 0;
    while (made < RAND_ITEMS) begin
      if (!paused && made >= RAND_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // Whole new matrix: strong diagonal, small off-diagonal terms.
        for (int k = 0; k < NUM_ELEMS; k++) begin
          row = w_row(4'(k), '0);
          b = row.beat;
          if (k[1:0] == k[3:2]) b.val = small_q(2 * int'(Q_ONE));
          else                  b.val = small_q(int'(Q_ONE) / 4);
          issue(b, 1'b0, 1'b0);
          pace();
        end
        made += NUM_ELEMS;
      end else if (pick < 15) begin
        row = w_row(4'($urandom), '0);
        b = row.beat;
        b.val = ($urandom_range(0, 9) < 7) ? small_q(2 * int'(Q_ONE)) : 32'($urandom);
        issue(b, 1'b0, 1'b0);
        pace();
        made++;
      end else begin
        if (pick < 80) begin
          // Box of modest size somewhere around the view volume.
          row = t_row('0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
          b = row.beat;
          ctr = small_q(8 * int'(Q_ONE)); half = $urandom_range(0, 2 * int'(Q_ONE));
          b.min_x = ctr - half; b.max_x = ctr + half;
          ctr = small_q(8 * int'(Q_ONE)); half = $urandom_range(0, 2 * int'(Q_ONE));
          b.min_y = ctr - half; b.max_y = ctr + half;
          ctr = small_q(8 * int'(Q_ONE)); half = $urandom_range(0, 2 * int'(Q_ONE));
          b.min_z = ctr - half; b.max_z = ctr + half;
          if ($urandom_range(0, 9) == 0) begin
            b.min_x = b.max_x;
            b.max_x = ctr - half;
          end
        end else begin
          row = t_row($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      1'b0, 1'b0);
          b = row.beat;
        end
        issue(b, 1'b0, 1'b0);
        pace();
        made++;
      end
    end

    drain();
    repeat (END_SETTLE) @(posedge clk);
    $display("Covered %0d matrix writes and %0d box tests (directed and random).",
             n_writes, n_tests);
    $display("Checked %0d result beats, %0d of them culled.", n_results, n_culled);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
